@@ sv/kpvt_pkg.sv @@
// shared constants, types and saturation helper for the position/velocity tracker
package kpvt_pkg;

	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PROCESS_NOISE = 1'b0;
	localparam cfg_idx_t CFG_MEASURE_NOISE = 1'b1;

	localparam logic [31:0] NOISE_RESET = 32'd32768;
	localparam logic signed [31:0] VAR_POS_RESET = 32'sd6553600;
	localparam logic signed [31:0] VAR_VEL_RESET = 32'sd65536;
	localparam logic signed [32:0] Q_ONE = 33'sd65536;
	localparam logic [19:0] DT_MIN = 20'd65;
	localparam logic [19:0] DT_SUB = 20'd655;
	localparam logic [15:0] ROUND_HALF = 16'h8000;

	// serial multiplier and divider step counts
	localparam int MUL_W = 34;
	localparam int DIV_STEPS = 48;

	typedef logic signed [55:0] wide_t;

	function automatic logic signed [31:0] sat32(input wide_t v);
		logic signed [31:0] r;
		if (v > 56'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -56'sh0000_0000_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ sv/kalman_position_velocity_tracker.sv @@
// constant-velocity kalman tracker with a bit-serial multiplier and divider
// sequence: a restart or first item goes straight to the result; a tracked item runs
//   ten serial multiplies plus two restoring divides
//   (the divides are skipped when the innovation variance is not positive)
// throughput: one item at a time; the next item is taken once the result is registered
// reset (arst_n low): noise registers 0.5, var_position 100.0, var_velocity 1.0,
//   estimates and cross term zero, no track
module kalman_position_velocity_tracker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  kpvt_pkg::cfg_idx_t       cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [31:0]       measurement,
	input  logic [19:0]              elapsed,
	input  logic                     restart,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [31:0]       position,
	output logic signed [31:0]       velocity
);
	import kpvt_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LAUNCH = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_RND    = 3'd3;
	localparam logic [2:0] ST_POST   = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_DFIN   = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	// operation steps, predict first then update
	localparam logic [3:0] OP_DT_VEL  = 4'd0;
	localparam logic [3:0] OP_DT_CC   = 4'd1;
	localparam logic [3:0] OP_DT_DT   = 4'd2;
	localparam logic [3:0] OP_DD_VV   = 4'd3;
	localparam logic [3:0] OP_DT_VV   = 4'd4;
	localparam logic [3:0] OP_DIV_KX  = 4'd5;
	localparam logic [3:0] OP_DIV_KV  = 4'd6;
	localparam logic [3:0] OP_KX_Y    = 4'd7;
	localparam logic [3:0] OP_KV_Y    = 4'd8;
	localparam logic [3:0] OP_OMK_VP  = 4'd9;
	localparam logic [3:0] OP_KV_CC   = 4'd10;
	localparam logic [3:0] OP_OMK_CC  = 4'd11;

	logic [2:0] state_q;
	logic [3:0] op_q;
	logic [5:0] cnt_q;

	// configuration
	logic [31:0] qn_q, rn_q;

	// filter state
	logic signed [31:0] pos_q, vel_q, vp_q, cc_q, vv_q;
	logic               track_q;

	// per-item working registers
	logic signed [31:0] z_q;
	logic [19:0]        dt_q;
	logic [24:0]        dd_q;
	logic signed [55:0] sum_q;
	logic signed [32:0] y_q;
	logic signed [33:0] s_q;
	logic signed [31:0] kx_q, kv_q;
	logic signed [51:0] m_q;

	// serial multiplier: hi accumulates, lo shifts multiplier bits out and product bits in
	logic signed [34:0] mul_hi_q;
	logic [33:0]        mul_lo_q;
	logic signed [33:0] mul_b_q;

	// restoring divider
	logic [33:0] rem_q;
	logic [47:0] dvd_q;
	logic [47:0] quo_q;
	logic        div_neg_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] pos_out_q, vel_out_q;

	logic signed [32:0] omk;
	logic signed [33:0] op_a, op_b;
	logic signed [31:0] div_num;
	logic signed [34:0] mul_add, mul_sum;
	logic [68:0]        prod_rnd;
	logic [34:0]        rem_shift;
	logic               rem_ge;
	logic signed [31:0] div_res;
	logic               s_pos;
	logic               out_free;
	logic signed [55:0] q_wide;

	assign omk      = Q_ONE - 33'(kx_q);
	assign q_wide   = 56'($signed({1'b0, qn_q}));
	assign s_pos    = !s_q[33] && (s_q != 34'sd0);
	assign out_free = !out_valid_q || out_ready;

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (op_q)
			OP_DT_VEL: begin op_a = 34'($signed({1'b0, dt_q})); op_b = 34'(vel_q); end
			OP_DT_CC:  begin op_a = 34'($signed({1'b0, dt_q})); op_b = 34'(cc_q); end
			OP_DT_DT:  begin
				op_a = 34'($signed({1'b0, dt_q}));
				op_b = 34'($signed({1'b0, dt_q}));
			end
			OP_DD_VV:  begin op_a = 34'($signed({1'b0, dd_q})); op_b = 34'(vv_q); end
			OP_DT_VV:  begin op_a = 34'($signed({1'b0, dt_q})); op_b = 34'(vv_q); end
			OP_KX_Y:   begin op_a = 34'(kx_q); op_b = 34'(y_q); end
			OP_KV_Y:   begin op_a = 34'(kv_q); op_b = 34'(y_q); end
			OP_OMK_VP: begin op_a = 34'(omk); op_b = 34'(vp_q); end
			OP_KV_CC:  begin op_a = 34'(kv_q); op_b = 34'(cc_q); end
			OP_OMK_CC: begin op_a = 34'(omk); op_b = 34'(cc_q); end
			default:   begin op_a = '0; op_b = '0; end
		endcase
	end

	assign div_num = (op_q == OP_DIV_KX) ? vp_q : cc_q;

	// one multiplier bit per cycle; the sign bit weighs negative
	always_comb begin
		if (!mul_lo_q[0]) begin
			mul_add = '0;
		end else if (cnt_q == 6'(MUL_W - 1)) begin
			mul_add = -35'(mul_b_q);
		end else begin
			mul_add = 35'(mul_b_q);
		end
		mul_sum = mul_hi_q + mul_add;
	end

	// round half up then floor by 2^16
	assign prod_rnd = {mul_hi_q, mul_lo_q} + 69'({ROUND_HALF});

	// one quotient bit per cycle
	assign rem_shift = {rem_q, dvd_q[47]};
	assign rem_ge    = rem_shift >= {1'b0, s_q[33:0]};

	// sign and saturation of the gain
	always_comb begin
		if (quo_q[47:31] != '0) begin
			div_res = div_neg_q ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			div_res = div_neg_q ? -$signed(quo_q[31:0]) : $signed(quo_q[31:0]);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign position  = pos_out_q;
	assign velocity  = vel_out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q <= NOISE_RESET;
			rn_q <= NOISE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROCESS_NOISE: qn_q <= cfg_data;
				CFG_MEASURE_NOISE: rn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			pos_out_q <= pos_q;
			vel_out_q <= vel_q;
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_DT_VEL;
			cnt_q   <= '0;
			pos_q   <= '0;
			vel_q   <= '0;
			vp_q    <= VAR_POS_RESET;
			cc_q    <= '0;
			vv_q    <= VAR_VEL_RESET;
			track_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						z_q  <= measurement;
						dt_q <= (elapsed <= DT_MIN) ? DT_SUB : elapsed;
						if (restart || !track_q) begin
							// fresh track: covariance kept
							pos_q   <= measurement;
							vel_q   <= '0;
							track_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							op_q    <= OP_DT_VEL;
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_LAUNCH: begin
					cnt_q <= '0;
					if (op_q == OP_DIV_KX && !s_pos) begin
						// no usable innovation variance: both gains zero
						kx_q <= '0;
						kv_q <= '0;
						op_q <= OP_KX_Y;
					end else if (op_q == OP_DIV_KX || op_q == OP_DIV_KV) begin
						div_neg_q <= div_num[31];
						dvd_q     <= {div_num[31] ? 32'(-div_num) : 32'(div_num), 16'd0};
						rem_q     <= '0;
						quo_q     <= '0;
						state_q   <= ST_DIV;
					end else begin
						mul_hi_q <= '0;
						mul_lo_q <= op_a;
						mul_b_q  <= op_b;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_hi_q <= {mul_sum[34], mul_sum[34:1]};
					mul_lo_q <= {mul_sum[0], mul_lo_q[33:1]};
					cnt_q    <= cnt_q + 6'd1;
					if (cnt_q == 6'(MUL_W - 1)) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					m_q     <= prod_rnd[67:16];
					state_q <= ST_POST;
				end
				ST_POST: begin
					op_q    <= op_q + 4'd1;
					state_q <= ST_LAUNCH;
					case (op_q)
						OP_DT_VEL: begin
							pos_q <= sat32(56'(pos_q) + 56'(m_q));
							sum_q <= 56'(vp_q) + q_wide;
						end
						OP_DT_CC: sum_q <= sum_q + (56'(m_q) <<< 1);
						OP_DT_DT: dd_q <= m_q[24:0];
						OP_DD_VV: vp_q <= sat32(sum_q + 56'(m_q));
						OP_DT_VV: begin
							cc_q <= sat32(56'(cc_q) + 56'(m_q));
							vv_q <= sat32(56'(vv_q) + q_wide);
							// innovation and its variance from the predicted state
							y_q  <= 33'(z_q) - 33'(pos_q);
							s_q  <= 34'(vp_q) + 34'($signed({1'b0, rn_q}));
						end
						OP_KX_Y:   pos_q <= sat32(56'(pos_q) + 56'(m_q));
						OP_KV_Y:   vel_q <= sat32(56'(vel_q) + 56'(m_q));
						OP_OMK_VP: vp_q <= sat32(56'(m_q));
						// the velocity variance sees the cross term before its update
						OP_KV_CC:  vv_q <= sat32(56'(vv_q) - 56'(m_q));
						OP_OMK_CC: begin
							cc_q    <= sat32(56'(m_q));
							state_q <= ST_DONE;
						end
						default: ;
					endcase
				end
				ST_DIV: begin
					rem_q <= rem_ge ? 34'(rem_shift - {1'b0, s_q[33:0]}) : rem_shift[33:0];
					quo_q <= {quo_q[46:0], rem_ge};
					dvd_q <= {dvd_q[46:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						state_q <= ST_DFIN;
					end
				end
				ST_DFIN: begin
					if (op_q == OP_DIV_KX) begin
						kx_q <= div_res;
					end else begin
						kv_q <= div_res;
					end
					op_q    <= op_q + 4'd1;
					state_q <= ST_LAUNCH;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ tb/sv/kpvt_track_checker.sv @@
// watches the tracker ports, predicts each filtered estimate and compares it
`timescale 1ns / 100ps
module kpvt_track_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  kpvt_pkg::cfg_idx_t   cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [31:0]   measurement,
	input  logic [19:0]          elapsed,
	input  logic                 restart,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [31:0]   position,
	input  logic signed [31:0]   velocity,
	output int                   pending,
	output int                   mismatches
);
	import kpvt_pkg::*;

	typedef logic signed [127:0] big_t;
	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
	} estimate_t;

	estimate_t estimate_q[$];

	logic [31:0]        q_noise, r_noise;
	logic signed [31:0] x_pos, x_vel, p_xx, p_xv, p_vv;
	logic               tracking;

	function automatic big_t fx_mul(input big_t a, input big_t b);
		big_t p;
		p = a * b + big_t'(32768);
		return p >>> 16;
	endfunction

	function automatic logic signed [31:0] fx_sat(input big_t v);
		logic signed [31:0] r;
		if (v > big_t'(32'sh7FFF_FFFF)) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -big_t'(64'sh8000_0000)) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	task automatic filter_step(input logic signed [31:0] z, input logic [19:0] dt_raw,
			input logic fresh);
		big_t dt, q, r, pxx, pxv, pvv, y, s, kx, kv, zb;
		estimate_t est;
		dt = big_t'({1'b0, dt_raw});
		zb = big_t'(z);
		if (dt_raw <= DT_MIN) begin
			dt = big_t'({1'b0, DT_SUB});
		end
		if (fresh || !tracking) begin
			x_pos = z;
			x_vel = '0;
			tracking = 1'b1;
		end else begin
			q = big_t'({1'b0, q_noise});
			r = big_t'({1'b0, r_noise});
			kx = '0;
			kv = '0;
			// predict
			x_pos = fx_sat(big_t'(x_pos) + fx_mul(dt, big_t'(x_vel)));
			pxx = big_t'(p_xx) + 2 * fx_mul(dt, big_t'(p_xv))
				+ fx_mul(fx_mul(dt, dt), big_t'(p_vv)) + q;
			pxv = big_t'(p_xv) + fx_mul(dt, big_t'(p_vv));
			pvv = big_t'(p_vv) + q;
			p_xx = fx_sat(pxx);
			p_xv = fx_sat(pxv);
			p_vv = fx_sat(pvv);
			// update, gains zero when the innovation variance is not positive
			y = zb - big_t'(x_pos);
			s = big_t'(p_xx) + r;
			if (s > 0) begin
				kx = big_t'(fx_sat((big_t'(p_xx) * 65536) / s));
				kv = big_t'(fx_sat((big_t'(p_xv) * 65536) / s));
			end
			x_pos = fx_sat(big_t'(x_pos) + fx_mul(kx, y));
			x_vel = fx_sat(big_t'(x_vel) + fx_mul(kv, y));
			pxv = big_t'(p_xv);
			p_xx = fx_sat(fx_mul(big_t'(Q_ONE) - kx, big_t'(p_xx)));
			p_xv = fx_sat(fx_mul(big_t'(Q_ONE) - kx, pxv));
			p_vv = fx_sat(big_t'(p_vv) - fx_mul(kv, pxv));
		end
		est.pos = x_pos;
		est.vel = x_vel;
		estimate_q.insert(estimate_q.size(), est);
	endtask

	always @(posedge clk or negedge arst_n) begin
		estimate_t e;
		if (!arst_n) begin
			q_noise = NOISE_RESET;
			r_noise = NOISE_RESET;
			x_pos = '0;
			x_vel = '0;
			p_xx = VAR_POS_RESET;
			p_xv = '0;
			p_vv = VAR_VEL_RESET;
			tracking = 1'b0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_PROCESS_NOISE) begin
					q_noise = cfg_data;
				end else begin
					r_noise = cfg_data;
				end
			end
			if (in_valid && in_ready) begin
				filter_step(measurement, elapsed, restart);
			end
			if (out_valid && out_ready) begin
				if (estimate_q.size() == 0) begin
					$error("unexpected result: position %0d velocity %0d", position, velocity);
					mismatches++;
				end else begin
					e = estimate_q.pop_front();
					if (position !== e.pos) begin
						$error("position: expected %0d, actual %0d", e.pos, position);
						mismatches++;
					end
					if (velocity !== e.vel) begin
						$error("velocity: expected %0d, actual %0d", e.vel, velocity);
						mismatches++;
					end
				end
			end
		end
		pending = estimate_q.size();
	end

endmodule

@@ tb/sv/tb.sv @@
// stimulus, configuration phases and verdict for the position/velocity tracker
`timescale 1ns / 100ps
module tb;
	import kpvt_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	cfg_idx_t           cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] measurement;
	logic [19:0]        elapsed;
	logic               restart;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	int                 pending;
	int                 mismatches;

	// registered view of the input handshake, read at the falling edge
	logic               item_taken;
	int                 sent_items;
	int                 restarts;
	logic signed [31:0] target_z;

	kalman_position_velocity_tracker i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.elapsed     (elapsed),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.velocity    (velocity)
	);

	kpvt_track_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.elapsed     (elapsed),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.velocity    (velocity),
		.pending     (pending),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= in_valid && in_ready;
		end
	end

	// hard stop well beyond the slowest legal run of all 520 items
	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	// receiver: cycles through always ready, coin flips and long stalls
	initial begin
		int mode;
		int left;
		int stall;
		out_ready = 1'b0;
		mode = 0;
		left = 0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(100, 2000);
			end
			left--;
			case (mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					// long stalls with short open windows
					if (stall > 0) begin
						stall--;
						out_ready <= 1'b0;
					end else begin
						stall = $urandom_range(0, 20);
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// one register write, only called while nothing is in flight
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// present one item and hold it until the block takes it
	task automatic send_item(input logic signed [31:0] z, input logic [19:0] dt,
			input logic fresh);
		in_valid <= 1'b1;
		measurement <= z;
		elapsed <= dt;
		restart <= fresh;
		do begin
			@(negedge clk);
		end while (!item_taken);
		sent_items++;
		if (fresh) begin
			restarts++;
		end
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		// settle time after the last result has been taken
		repeat (8) @(negedge clk);
	endtask

	// mostly a plausible track with random content, the rest full-range noise
	task automatic send_random_item();
		logic signed [31:0] z;
		logic [19:0]        dt;
		logic               fresh;
		int                 pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			target_z = target_z + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			z = target_z + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		end else begin
			z = $urandom;
		end
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			dt = 20'($urandom_range(0, 100));
		end else if (pick < 80) begin
			dt = 20'($urandom_range(655, 13107));
		end else begin
			dt = 20'($urandom_range(0, 20'hFFFFF));
		end
		fresh = ($urandom_range(0, 99) < 5);
		send_item(z, dt, fresh);
	endtask

	// burst of random items with random gaps, sometimes no gaps at all
	task automatic random_phase(input int count);
		int n;
		int burst;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && n < count) begin
				send_random_item();
				burst--;
				n++;
			end
			if ($urandom_range(0, 3) != 0) begin
				idle_cycles($urandom_range(1, 10));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PROCESS_NOISE;
		cfg_data = '0;
		in_valid = 1'b0;
		measurement = '0;
		elapsed = '0;
		restart = 1'b0;
		sent_items = 0;
		restarts = 0;
		target_z = 32'sd6553600;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: first item builds the track, then tracked items, restarts and extremes
		send_item(32'sd655360, 20'd0, 1'b0);
		send_item(32'sd720896, 20'd0, 1'b0);
		send_item(32'sd786432, 20'd65, 1'b0);
		send_item(32'sd851968, 20'd66, 1'b0);
		send_item(32'sd917504, 20'd6553, 1'b0);
		send_item(32'sh7FFF_FFFF, 20'hFFFFF, 1'b0);
		send_item(32'sh8000_0000, 20'hFFFFF, 1'b0);
		send_item(32'sh8000_0000, 20'd65535, 1'b0);
		send_item(32'sh7FFF_FFFF, 20'd1, 1'b0);
		send_item(32'sd0, 20'd655, 1'b1);
		send_item(-32'sd131072, 20'd3276, 1'b0);
		send_item(32'sh7FFF_FFFF, 20'd0, 1'b1);
		send_item(32'sh7FFF_FFF0, 20'hFFFFF, 1'b0);
		send_item(-32'sd1, 20'd64, 1'b0);
		drain();

		// low noise extremes: no process noise, smallest measurement noise
		write_reg(CFG_PROCESS_NOISE, 32'd0);
		write_reg(CFG_MEASURE_NOISE, 32'd1);
		send_item(32'sd1000, 20'd655, 1'b1);
		send_item(32'sd2000, 20'd655, 1'b0);
		send_item(32'sd3000, 20'd0, 1'b0);
		random_phase(100);
		drain();

		// high noise extremes, variance sums run into saturation
		write_reg(CFG_PROCESS_NOISE, 32'hFFFF_FFFF);
		write_reg(CFG_MEASURE_NOISE, 32'hFFFF_FFFF);
		send_item(32'sd0, 20'd655, 1'b1);
		send_item(32'sh4000_0000, 20'hFFFFF, 1'b0);
		send_item(32'shC000_0000, 20'hFFFFF, 1'b0);
		random_phase(80);
		drain();

		// mixed settings with random register values
		write_reg(CFG_PROCESS_NOISE, $urandom_range(0, 1 << 20));
		write_reg(CFG_MEASURE_NOISE, $urandom_range(1, 1 << 22));
		random_phase(120);
		// hold off until every result is back, then resume
		drain();
		random_phase(80);
		drain();

		write_reg(CFG_PROCESS_NOISE, $urandom);
		write_reg(CFG_MEASURE_NOISE, $urandom | 32'd1);
		random_phase(60);
		drain();

		// back to the reset values for the last stretch
		write_reg(CFG_PROCESS_NOISE, NOISE_RESET);
		write_reg(CFG_MEASURE_NOISE, NOISE_RESET);
		random_phase(60);
		drain();
		repeat (500) @(negedge clk);

		$display("covered %0d items (%0d restarts) over six noise settings", sent_items,
			restarts);
		$display("including zero and full-scale noise, short and maximal elapsed times");
		if (mismatches == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ kalman_position_velocity_tracker.f @@
sv/kpvt_pkg.sv
sv/kalman_position_velocity_tracker.sv
tb/sv/kpvt_track_checker.sv
tb/sv/tb.sv
